@@ design/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg: time-slice task release scheduler package
// Function codes, task numbering, status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int TASK_COUNT_DEF = 8;

  localparam logic [7:0] LIMIT_100_RST = 8'd100;
  localparam logic [7:0] LIMIT_50_RST  = 8'd25;
  localparam logic [7:0] LIMIT_10_RST  = 8'd5;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ACTIVATE = 2'd1,
    FUNC_COMPLETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_INIT     = 2'd0,
    STAT_RUN      = 2'd1,
    STAT_OVERLOAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_LIMIT_100 = 2'd0,
    CFG_LIMIT_50  = 2'd1,
    CFG_LIMIT_10  = 2'd2
  } cfg_idx_t;

  localparam logic [2:0] TID_1MS   = 3'd0;
  localparam logic [2:0] TID_2MSA  = 3'd1;
  localparam logic [2:0] TID_2MSB  = 3'd2;
  localparam logic [2:0] TID_10MS  = 3'd3;
  localparam logic [2:0] TID_50MS  = 3'd4;
  localparam logic [2:0] TID_100MS = 3'd5;

  localparam logic [7:0] SLICE_ODD  = 8'h01;
  localparam logic [7:0] SLICE_GRPA = 8'h02;

endpackage

@@ design/time_slice_task_release_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// time_slice_task_release_scheduler_top: cyclic executive task release
// Ticks advance the slice counter and release threads; activation and
// completion items update the ready, overrun and status state.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_func, in_task_id
//   out      out_valid/out_stall out_thread_id, out_ready_mask,
//                                out_overload_mask, out_sched_status
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle unless the result is stalled; each item passes the input
// register, then the state update that loads the result. Reset clears the valid
// flags and scheduler state and loads default limits. A stalled result holds the
// state; the input register keeps accepting until it is full.
// ----------------------------------------------------------------------------
module time_slice_task_release_scheduler_top
  import tsr_pkg::*;
#(
  parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_task_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_thread_id,
  output logic [7:0] out_ready_mask,
  output logic [7:0] out_overload_mask,
  output logic [1:0] out_sched_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int IDW = $clog2(TASK_COUNT);

  logic             in_valid_r;
  logic [1:0]       func_r;
  logic [3:0]       id_r;
  logic             out_valid_r;
  logic             out_free;
  logic             proc;

  logic [7:0]       limit_100_r;
  logic [7:0]       limit_50_r;
  logic [7:0]       limit_10_r;

  logic [7:0]       slice_r;
  logic [7:0]       slice_nxt;
  logic [2:0]       thread_r;
  logic [2:0]       thread_nxt;
  logic [TASK_COUNT-1:0] ready_r;
  logic [TASK_COUNT-1:0] ready_nxt;
  logic [TASK_COUNT-1:0] over_r;
  logic [TASK_COUNT-1:0] over_nxt;
  logic [7:0]       stamp_r   [TASK_COUNT];
  logic [7:0]       stamp_nxt [TASK_COUNT];
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;

  logic [7:0]       slice_inc;
  logic             tick;
  logic             sl_odd;
  logic             sl_grpa;
  logic             en_slow;
  logic             en_mid;
  logic             en_fast;
  logic             due_slow;
  logic             due_mid;
  logic             due_fast;
  logic             id_ok;
  logic [IDW-1:0]   idx;
  logic [15:0]      ready_ext;
  logic [15:0]      over_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign proc      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r <= in_func;
      id_r   <= in_task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_100_r <= LIMIT_100_RST;
      limit_50_r  <= LIMIT_50_RST;
      limit_10_r  <= LIMIT_10_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIMIT_100: limit_100_r <= cfg_data;
        CFG_LIMIT_50:  limit_50_r  <= cfg_data;
        CFG_LIMIT_10:  limit_10_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slice_inc = slice_r + 8'd1;
  assign tick      = proc && (func_r == FUNC_TICK);
  assign sl_odd    = (slice_inc & SLICE_ODD) == SLICE_ODD;
  assign sl_grpa   = !sl_odd && ((slice_inc & SLICE_GRPA) == SLICE_GRPA);
  assign en_slow   = tick && sl_odd;
  assign en_mid    = tick && sl_grpa;
  assign en_fast   = tick && !sl_odd && !sl_grpa;

  tsr_divider u_div_slow (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en_slow),
    .limit (limit_100_r),
    .due   (due_slow)
  );

  tsr_divider u_div_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en_mid),
    .limit (limit_50_r),
    .due   (due_mid)
  );

  tsr_divider u_div_fast (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en_fast),
    .limit (limit_10_r),
    .due   (due_fast)
  );

  assign id_ok = ({1'b0, id_r} < 5'(TASK_COUNT));
  assign idx   = id_r[IDW-1:0];

  always_comb begin
    slice_nxt  = slice_r;
    thread_nxt = thread_r;
    ready_nxt  = ready_r;
    over_nxt   = over_r;
    status_nxt = status_r;
    stamp_nxt  = stamp_r;
    if (proc) begin
      case (func_r)
        FUNC_TICK: begin
          slice_nxt = slice_inc;
          if (sl_odd) begin
            ready_nxt[IDW'(TID_1MS)] = 1'b1;
            stamp_nxt[IDW'(TID_1MS)] = slice_inc;
            thread_nxt = TID_1MS;
            if (due_slow) begin
              ready_nxt[IDW'(TID_100MS)] = 1'b1;
              stamp_nxt[IDW'(TID_100MS)] = slice_inc;
              thread_nxt = TID_100MS;
            end
          end else if (sl_grpa) begin
            ready_nxt[IDW'(TID_2MSA)] = 1'b1;
            stamp_nxt[IDW'(TID_2MSA)] = slice_inc;
            thread_nxt = TID_2MSA;
            if (due_mid) begin
              ready_nxt[IDW'(TID_50MS)] = 1'b1;
              stamp_nxt[IDW'(TID_50MS)] = slice_inc;
              thread_nxt = TID_50MS;
            end
          end else begin
            ready_nxt[IDW'(TID_2MSB)] = 1'b1;
            stamp_nxt[IDW'(TID_2MSB)] = slice_inc;
            thread_nxt = TID_2MSB;
            if (due_fast) begin
              ready_nxt[IDW'(TID_10MS)] = 1'b1;
              stamp_nxt[IDW'(TID_10MS)] = slice_inc;
              thread_nxt = TID_10MS;
            end
          end
        end
        FUNC_ACTIVATE: begin
          if (id_ok) begin
            ready_nxt[idx] = 1'b1;
          end
        end
        FUNC_COMPLETE: begin
          if (id_ok && ready_r[idx]) begin
            ready_nxt[idx] = 1'b0;
            if (slice_r != stamp_r[idx]) begin
              over_nxt[idx] = 1'b1;
              status_nxt    = STAT_OVERLOAD;
            end else begin
              status_nxt    = STAT_RUN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r  <= '0;
      thread_r <= TID_1MS;
      ready_r  <= '0;
      over_r   <= '0;
      status_r <= STAT_INIT;
      for (int i = 0; i < TASK_COUNT; i++) begin
        stamp_r[i] <= '0;
      end
    end else begin
      slice_r  <= slice_nxt;
      thread_r <= thread_nxt;
      ready_r  <= ready_nxt;
      over_r   <= over_nxt;
      status_r <= status_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  assign ready_ext = 16'(ready_r);
  assign over_ext  = 16'(over_r);

  assign out_valid         = out_valid_r;
  assign out_thread_id     = thread_r;
  assign out_ready_mask    = ready_ext[7:0];
  assign out_overload_mask = over_ext[7:0];
  assign out_sched_status  = status_r;

endmodule

@@ design/tsr_divider.sv @@
// ----------------------------------------------------------------------------
// tsr_divider: slice divider
// Counts slices of one kind and flags when the slower thread is due.
// ----------------------------------------------------------------------------
module tsr_divider
  import tsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] limit,
  output logic       due
);

  logic [7:0] count_r;
  logic [7:0] count_inc;
  logic [7:0] count_nxt;

  assign count_inc = count_r + 8'd1;
  assign due       = (count_inc >= limit);

  always_comb begin
    count_nxt = count_r;
    if (en) begin
      count_nxt = due ? 8'd0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
